### rtl/ipv4_exact_route_forward_assert.svh
// Assertion macros for the route forwarding block.
`ifndef IPV4_EXACT_ROUTE_FORWARD_ASSERT_SVH
`define IPV4_EXACT_ROUTE_FORWARD_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define IERF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define IERF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/ierf_pkg.sv
// Package: types, constants and hash for the route forwarding block.
package ierf_pkg;
  localparam int TABLE_ENTRIES = 8192;
  localparam int PROBE_LIMIT   = 8;
  localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
  localparam int PROBE_W = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int ENTRY_W = 1 + 32 + 48 + 48 + 8;

  localparam logic [1:0] CMD_FWD = 2'd0;
  localparam logic [1:0] CMD_WR  = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  localparam logic [2:0] OUT_PASS   = 3'd0;
  localparam logic [2:0] OUT_REDIR  = 3'd1;
  localparam logic [2:0] OUT_DONE   = 3'd2;
  localparam logic [2:0] OUT_FULL   = 3'd3;
  localparam logic [2:0] OUT_ABSENT = 3'd4;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [31:0] dst_ip;
    logic [7:0]  ingress_port;
    logic [47:0] route_dst_mac;
    logic [47:0] route_src_mac;
    logic [7:0]  route_port;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [7:0]  egress_port;
    logic [47:0] new_dst_mac;
    logic [47:0] new_src_mac;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [47:0] next_mac;
    logic [47:0] own_mac;
    logic [7:0]  port;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture input item, start probing
    logic probe;     // issue read of current probe slot
    logic check;     // examine returned entry
    logic clr;       // clearing pass write
    logic finish;    // form result, apply table update
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;
    logic last_probe;
    logic bypass;    // item needs no lookup
  } stat_t;

  function automatic logic [SLOT_W-1:0] home_slot(input logic [31:0] key);
    logic [31:0] h;
    h = key * 32'h9E3779B1;
    h = h ^ (h >> 16);
    return h[SLOT_W-1:0];
  endfunction
endpackage

### rtl/ierf_if.sv
// Valid/ready channel interface carrying one item.
interface ierf_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/ierf_ram.sv
// Generic single port RAM with registered read.
module ierf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### rtl/ierf_ctrl.sv
// Controller state machine: clearing pass, probe sequence, result hand-off.
module ierf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ierf_pkg::stat_t st,
  output ierf_pkg::cmd_t  cm
);
  import ierf_pkg::*;
  typedef enum logic [5:0] {
    S_CLR   = 6'b000001,
    S_IDLE  = 6'b000010,
    S_PROBE = 6'b000100,
    S_CHECK = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cm = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cm.clr = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cm.load = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (st.bypass) state_nxt = S_FIN;
        else begin
          cm.probe = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cm.check = 1'b1;
        state_nxt = st.last_probe ? S_FIN : S_PROBE;
      end
      S_FIN: begin
        cm.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end
endmodule

### rtl/ierf_dp.sv
// Datapath: item capture, probe addressing, match search, table update.
module ierf_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ierf_pkg::in_item_t   in_data,
  input  ierf_pkg::cmd_t       cm,
  output ierf_pkg::stat_t      st,
  output ierf_pkg::out_item_t  out_data
);
  import ierf_pkg::*;
  in_item_t          item_r;
  logic [SLOT_W-1:0] home_r, clr_r, clr_nxt;
  logic [PROBE_W-1:0] idx_r, idx_nxt;
  logic              hit_r, hit_nxt, free_r, free_nxt;
  logic [SLOT_W-1:0] hit_slot_r, hit_slot_nxt, free_slot_r, free_slot_nxt;
  entry_t            hit_ent_r, hit_ent_nxt;
  logic [SLOT_W-1:0] probe_addr, ram_addr;
  logic              ram_we;
  entry_t            ram_wdata, rd;
  out_item_t         res_r, res_nxt;
  logic              bypass;

  assign probe_addr = home_r + SLOT_W'(idx_r);
  assign bypass = (item_r.cmd == CMD_FWD) ?
                  (item_r.frame_length < 16'd34 || item_r.ether_type != ETH_IPV4) :
                  (item_r.cmd != CMD_WR && item_r.cmd != CMD_DEL);

  assign st.clr_last   = (clr_r == SLOT_W'(TABLE_ENTRIES - 1));
  assign st.last_probe = (idx_r == PROBE_W'(PROBE_LIMIT - 1));
  assign st.bypass     = bypass;

  ierf_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(rd)
  );

  always_comb begin
    ram_we = 1'b0;
    ram_addr = probe_addr;
    ram_wdata = '0;
    res_nxt = res_r;
    if (cm.clr) begin
      ram_we = 1'b1;
      ram_addr = clr_r;
    end else if (cm.finish) begin
      res_nxt = '0;
      priority if (bypass) begin
        res_nxt.outcome = OUT_PASS;
      end else if (item_r.cmd == CMD_FWD) begin
        if (hit_r && hit_ent_r.port != item_r.ingress_port) begin
          res_nxt.outcome = OUT_REDIR;
          res_nxt.egress_port = hit_ent_r.port;
          res_nxt.new_dst_mac = hit_ent_r.next_mac;
          res_nxt.new_src_mac = hit_ent_r.own_mac;
        end
      end else if (item_r.cmd == CMD_WR) begin
        if (hit_r || free_r) begin
          ram_we = 1'b1;
          ram_addr = hit_r ? hit_slot_r : free_slot_r;
          ram_wdata = {1'b1, item_r.dst_ip, item_r.route_dst_mac,
                       item_r.route_src_mac, item_r.route_port};
          res_nxt.outcome = OUT_DONE;
        end else res_nxt.outcome = OUT_FULL;
      end else begin
        if (hit_r) begin
          ram_we = 1'b1;
          ram_addr = hit_slot_r;
          ram_wdata = hit_ent_r;
          ram_wdata.valid = 1'b0;
          res_nxt.outcome = OUT_DONE;
        end else res_nxt.outcome = OUT_ABSENT;
      end
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    hit_nxt = hit_r;
    free_nxt = free_r;
    hit_slot_nxt = hit_slot_r;
    free_slot_nxt = free_slot_r;
    hit_ent_nxt = hit_ent_r;
    clr_nxt = cm.clr ? clr_r + 1'b1 : clr_r;
    if (cm.load) begin
      idx_nxt = '0;
      hit_nxt = 1'b0;
      free_nxt = 1'b0;
    end else if (cm.check) begin
      // first match and first free slot of the window
      if (rd.valid && rd.key == item_r.dst_ip && !hit_r) begin
        hit_nxt = 1'b1;
        hit_slot_nxt = probe_addr;
        hit_ent_nxt = rd;
      end
      if (!rd.valid && !free_r) begin
        free_nxt = 1'b1;
        free_slot_nxt = probe_addr;
      end
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      hit_r <= 1'b0;
      free_r <= 1'b0;
      idx_r <= '0;
    end else begin
      clr_r <= clr_nxt;
      hit_r <= hit_nxt;
      free_r <= free_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cm.load) begin
      item_r <= in_data;
      home_r <= home_slot(in_data.dst_ip);
    end
    hit_slot_r <= hit_slot_nxt;
    free_slot_r <= free_slot_nxt;
    hit_ent_r <= hit_ent_nxt;
    res_r <= res_nxt;
  end

  assign out_data = res_r;
endmodule

### rtl/ipv4_exact_route_forward.sv
// Top level of the IPv4 exact-match host route forwarding block.
// Each item is either a frame header summary to forward or a route write or
// delete, and each yields exactly one result item. After reset the block
// runs a clearing pass over the 8192-slot route table, one slot a cycle, and
// takes no item until that pass ends. Two kinds of item skip the table
// lookup: a frame that fails the length or ethertype checks, and an unused
// command code. Such an item goes from the probe state straight to forming
// its result. A lookup, write or delete reads all 8 slots of the probe
// window in turn through the single table memory port, a read state and a
// check state per slot, before its result is formed and offered. One item is
// in flight at a time, and the next is taken the cycle after its result is
// taken.
module ipv4_exact_route_forward (
  input logic clk,
  input logic rst_n,
  ierf_if.sink   in_ch,
  ierf_if.source out_ch
);
  import ierf_pkg::*;
  cmd_t  cm;
  stat_t st;

  // sequence probes and hand-off
  ierf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .st(st), .cm(cm)
  );

  // hold item, search window, update table
  ierf_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_data(in_ch.data), .cm(cm), .st(st), .out_data(out_ch.data)
  );
endmodule

### rtl/ierf_checker.sv
// Port-level checker for the route forwarding block, bound to the top level.
`include "ipv4_exact_route_forward_assert.svh"
module ierf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] outcome,
  input logic [7:0] egress_port
);
  import ierf_pkg::*;
  `IERF_ASSERT_IMPL(a_one_side, clk, rst_n, out_valid, !in_ready)
  `IERF_ASSERT_NEXT(a_no_quick, clk, rst_n, in_valid && in_ready, !out_valid)
  `IERF_ASSERT_IMPL(a_port_zero, clk, rst_n, out_valid && outcome != OUT_REDIR, egress_port == '0)
  `IERF_ASSERT_IMPL(a_code, clk, rst_n, out_valid, outcome <= OUT_ABSENT)
  `IERF_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(outcome))
endmodule

bind ipv4_exact_route_forward ierf_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .outcome(out_ch.data.outcome), .egress_port(out_ch.data.egress_port)
);

### test/ipv4_route_forward_checker.sv
// Checker for the route forwarding block: predicts each result and compares it.
`timescale 1ns / 100ps

module ipv4_route_forward_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  ierf_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  ierf_pkg::out_item_t out_data,
  output int                 errors,
  output int                 pending
);
  import ierf_pkg::*;
  localparam int NO_HIT = -1;

  bit          route_live [TABLE_ENTRIES];
  logic [31:0] route_addr [TABLE_ENTRIES];
  logic [47:0] route_next [TABLE_ENTRIES];
  logic [47:0] route_own  [TABLE_ENTRIES];
  logic [7:0]  route_egr  [TABLE_ENTRIES];

  out_item_t expected_results[$];

  function automatic int route_home(input logic [31:0] key);
    logic [31:0] mix;
    mix = key * 32'h9E3779B1;
    mix = mix ^ {16'h0, mix[31:16]};
    return int'(mix % TABLE_ENTRIES);
  endfunction

  function automatic int slot_of(input logic [31:0] key, input bit want_free);
    int base;
    int s;
    base = route_home(key);
    for (int i = 0; i < PROBE_LIMIT; i++) begin
      s = (base + i) % TABLE_ENTRIES;
      if (want_free && !route_live[s]) return s;
      if (!want_free && route_live[s] && route_addr[s] == key) return s;
    end
    return NO_HIT;
  endfunction

  // Work out the decision for one item and apply its table update.
  function automatic out_item_t forward_decision(input in_item_t it);
    out_item_t r;
    int s;
    r = '0;
    case (it.cmd)
      CMD_FWD: begin
        if (it.frame_length >= 16'd34 && it.ether_type == ETH_IPV4) begin
          s = slot_of(it.dst_ip, 1'b0);
          if (s != NO_HIT && route_egr[s] != it.ingress_port) begin
            r.outcome     = OUT_REDIR;
            r.egress_port = route_egr[s];
            r.new_dst_mac = route_next[s];
            r.new_src_mac = route_own[s];
          end
        end
      end
      CMD_WR: begin
        s = slot_of(it.dst_ip, 1'b0);
        if (s == NO_HIT) s = slot_of(it.dst_ip, 1'b1);
        if (s == NO_HIT) begin
          r.outcome = OUT_FULL;
        end else begin
          route_live[s] = 1'b1;
          route_addr[s] = it.dst_ip;
          route_next[s] = it.route_dst_mac;
          route_own[s]  = it.route_src_mac;
          route_egr[s]  = it.route_port;
          r.outcome     = OUT_DONE;
        end
      end
      CMD_DEL: begin
        s = slot_of(it.dst_ip, 1'b0);
        if (s == NO_HIT) begin
          r.outcome = OUT_ABSENT;
        end else begin
          route_live[s] = 1'b0;
          r.outcome     = OUT_DONE;
        end
      end
      default: r.outcome = OUT_PASS;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      errors  = 0;
      pending = 0;
      expected_results.delete();
      for (int i = 0; i < TABLE_ENTRIES; i++) route_live[i] = 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(forward_decision(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.outcome !== want.outcome) begin
            $display("%0t: outcome expected %h actual %h", $time, want.outcome,
                     out_data.outcome);
            errors++;
          end
          if (out_data.egress_port !== want.egress_port) begin
            $display("%0t: egress_port expected %h actual %h", $time, want.egress_port,
                     out_data.egress_port);
            errors++;
          end
          if (out_data.new_dst_mac !== want.new_dst_mac) begin
            $display("%0t: new_dst_mac expected %h actual %h", $time, want.new_dst_mac,
                     out_data.new_dst_mac);
            errors++;
          end
          if (out_data.new_src_mac !== want.new_src_mac) begin
            $display("%0t: new_src_mac expected %h actual %h", $time, want.new_src_mac,
                     out_data.new_src_mac);
            errors++;
          end
        end
      end
      pending = expected_results.size();
    end
  end
endmodule

### test/ipv4_exact_route_forward_test.sv
// Top of the route forwarding testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module ipv4_exact_route_forward_test;
  import ierf_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int GROUP_SIZE   = PROBE_LIMIT + 1;
  // Home slot near the top of the table, so the probe window wraps to slot 0.
  localparam int WRAP_HOME    = TABLE_ENTRIES - 4;
  localparam int HOLD_CYCLES  = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ierf_if #(.item_t(in_item_t))  in_ch();
  ierf_if #(.item_t(out_item_t)) out_ch();

  int errors;
  int pending;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_count = 0;

  logic [31:0] key_pool[$];

  ipv4_exact_route_forward i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  ipv4_route_forward_checker i_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_ch.data),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data (out_ch.data),
    .errors   (errors),
    .pending  (pending)
  );

  always #2 clk = ~clk;

  // Guard against a hung handshake: the clearing pass plus a slow run fits well inside.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: stall at random, or hold off entirely for a counted stretch on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        hold_count++;
        if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic logic [47:0] rand_mac();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[47:0];
  endfunction

  function automatic in_item_t make_item(logic [1:0] cmd, logic [15:0] flen,
                                         logic [15:0] etype, logic [31:0] ip,
                                         logic [7:0] iport, logic [47:0] dmac,
                                         logic [47:0] smac, logic [7:0] rport);
    in_item_t it;
    it.cmd           = cmd;
    it.frame_length  = flen;
    it.ether_type    = etype;
    it.dst_ip        = ip;
    it.ingress_port  = iport;
    it.route_dst_mac = dmac;
    it.route_src_mac = smac;
    it.route_port    = rport;
    return it;
  endfunction

  // Offer one item and hold it until accepted; valid stays high for a follow-on item.
  task automatic send_item(input in_item_t it);
    int gap;
    logic [223:0] junk;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      in_ch.data  = junk[$bits(in_item_t)-1:0];
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = it;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Random item of any kind, mostly on a pooled key; few ports so same-port hits occur.
  function automatic in_item_t random_item();
    logic [31:0] key;
    logic [7:0]  port;
    int pick;
    pick = $urandom_range(99);
    key  = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(key_pool.size() - 1)];
    port = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    if (pick < 40)
      return make_item(CMD_FWD, 16'($urandom_range(34, 65535)), ETH_IPV4, key, port,
                       rand_mac(), rand_mac(), 8'($urandom));
    if (pick < 55)
      return make_item(CMD_FWD, 16'($urandom), ($urandom_range(1) ? ETH_IPV4 : 16'($urandom)),
                       key, 8'($urandom), rand_mac(), rand_mac(), 8'($urandom));
    if (pick < 80)
      return make_item(CMD_WR, 16'($urandom), 16'($urandom), key, 8'($urandom),
                       rand_mac(), rand_mac(), port);
    if (pick < 95)
      return make_item(CMD_DEL, 16'($urandom), 16'($urandom), key, 8'($urandom),
                       rand_mac(), rand_mac(), 8'($urandom));
    return make_item(2'd3, 16'($urandom), 16'($urandom), key, 8'($urandom),
                     rand_mac(), rand_mac(), 8'($urandom));
  endfunction

  initial begin
    logic [31:0] k;
    logic [31:0] group[$];
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Collect keys that share one home slot, enough to overflow the probe window.
    while (group.size() < GROUP_SIZE) begin
      k = $urandom;
      if (i_check.route_home(k) == WRAP_HOME) group.push_back(k);
    end
    for (int i = 0; i < GROUP_SIZE; i++) key_pool.push_back(group[i]);
    key_pool.push_back(32'h0);
    key_pool.push_back(32'hFFFF_FFFF);
    for (int i = 0; i < 14; i++) key_pool.push_back($urandom);

    // Directed: header checks at their boundaries and the unused command.
    send_item(make_item(CMD_FWD, 16'd0, ETH_IPV4, 32'h0, 8'd0, '0, '0, 8'd0));
    send_item(make_item(CMD_FWD, 16'd13, ETH_IPV4, 32'h0, 8'd0, '0, '0, 8'd0));
    send_item(make_item(CMD_FWD, 16'd33, ETH_IPV4, 32'h0, 8'd0, '0, '0, 8'd0));
    send_item(make_item(CMD_FWD, 16'hFFFF, 16'hFFFF, 32'h0, 8'hFF, '1, '1, 8'hFF));
    send_item(make_item(2'd3, 16'hFFFF, ETH_IPV4, 32'hFFFF_FFFF, 8'hFF, '1, '1, 8'hFF));
    // Delete of an absent key, then writes at the key extremes.
    send_item(make_item(CMD_DEL, 16'd0, 16'd0, 32'h0, 8'd0, '0, '0, 8'd0));
    send_item(make_item(CMD_WR, 16'd0, 16'd0, 32'h0, 8'd0, '0, '0, 8'hFF));
    send_item(make_item(CMD_WR, 16'd0, 16'd0, 32'hFFFF_FFFF, 8'd0, '1, '1, 8'd0));
    // Hit to another port redirects; hit to the same port and a short frame pass.
    send_item(make_item(CMD_FWD, 16'd34, ETH_IPV4, 32'h0, 8'd0, '0, '0, 8'd0));
    send_item(make_item(CMD_FWD, 16'd14, ETH_IPV4, 32'h0, 8'd0, '0, '0, 8'd0));
    send_item(make_item(CMD_FWD, 16'd34, ETH_IPV4, 32'hFFFF_FFFF, 8'd0, '0, '0, 8'd0));
    send_item(make_item(CMD_FWD, 16'hFFFF, ETH_IPV4, 32'hFFFF_FFFF, 8'd1, '0, '0, 8'd0));
    // Update in place, then forward again.
    send_item(make_item(CMD_WR, 16'd0, 16'd0, 32'h0, 8'd0, 48'h0123_4567_89AB,
                        48'hFEDC_BA98_7654, 8'd7));
    send_item(make_item(CMD_FWD, 16'd100, ETH_IPV4, 32'h0, 8'hFF, '0, '0, 8'd0));
    // Fill the wrapping window, overflow it, free a slot and retry.
    for (int i = 0; i < PROBE_LIMIT; i++)
      send_item(make_item(CMD_WR, 16'd0, 16'd0, group[i], 8'd0, rand_mac(), rand_mac(),
                          8'(i + 1)));
    send_item(make_item(CMD_WR, 16'd0, 16'd0, group[PROBE_LIMIT], 8'd0, '1, '0, 8'd9));
    send_item(make_item(CMD_DEL, 16'd0, 16'd0, group[2], 8'd0, '0, '0, 8'd0));
    send_item(make_item(CMD_WR, 16'd0, 16'd0, group[PROBE_LIMIT], 8'd0, '1, '0, 8'd9));
    send_item(make_item(CMD_FWD, 16'd60, ETH_IPV4, group[PROBE_LIMIT], 8'd0, '0, '0, 8'd0));
    send_item(make_item(CMD_FWD, 16'd60, ETH_IPV4, group[7], 8'd0, '0, '0, 8'd0));

    // Random part in four idling phases.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case (i)
        0: begin
          tx_idle_pct = 0;  rx_stall_pct = 0;
        end
        RANDOM_ITEMS / 4: begin
          tx_idle_pct = 62; rx_stall_pct = 0;
        end
        RANDOM_ITEMS / 2: begin
          // Hold the receiver off while items keep coming, so the input backs up.
          tx_idle_pct = 0;  rx_stall_pct = 62;
          hold_req = 1'b1;
        end
        3 * RANDOM_ITEMS / 4: begin
          // Pause the sender until every outstanding result has come back.
          drain_results();
          tx_idle_pct = 27; rx_stall_pct = 27;
        end
        default: ;
      endcase
      send_item(random_item());
    end

    drain_results();
    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
